// ----- src/rcsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsr_pkg
// Addresses, field masks and helpers for the RV64 CSR file.
// ----------------------------------------------------------------------------
package rcsr_pkg;

  localparam int CSR_COUNT = 4096;
  localparam int CSR_AW    = $clog2(CSR_COUNT);
  localparam int XLEN      = 64;
  localparam int DELEG_W   = 16;

  typedef logic [CSR_AW-1:0] csr_addr_t;
  typedef logic [XLEN-1:0]   xdata_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } csr_op_t;

  localparam csr_addr_t A_SSTATUS   = 12'h100;
  localparam csr_addr_t A_SIE       = 12'h104;
  localparam csr_addr_t A_SIP       = 12'h144;
  localparam csr_addr_t A_SATP      = 12'h180;
  localparam csr_addr_t A_MSTATUS   = 12'h300;
  localparam csr_addr_t A_MISA      = 12'h301;
  localparam csr_addr_t A_MEDELEG   = 12'h302;
  localparam csr_addr_t A_MIDELEG   = 12'h303;
  localparam csr_addr_t A_MIE       = 12'h304;
  localparam csr_addr_t A_MIP       = 12'h344;
  localparam csr_addr_t A_TSELECT   = 12'h7A0;
  localparam csr_addr_t A_TDATA1    = 12'h7A1;
  localparam csr_addr_t A_MVENDORID = 12'hF11;
  localparam csr_addr_t A_MARCHID   = 12'hF12;
  localparam csr_addr_t A_MIMPID    = 12'hF13;

  localparam xdata_t S_INT_MASK      = 64'h0000_0000_0000_0222;
  localparam xdata_t M_INT_MASK      = 64'h0000_0000_0000_0AAA;
  localparam xdata_t SSTATUS_RD_MASK = 64'h8000_0003_000D_E762;
  localparam xdata_t SSTATUS_WR_MASK = 64'h0000_0000_000C_0122;
  localparam xdata_t MSTATUS_WR_MASK = 64'h0000_0000_007E_19AA;
  localparam xdata_t MISA_RESET      = 64'h8000_0000_0014_1101;
  localparam xdata_t MSTATUS_RESET   = 64'h0000_000A_0000_0000;

  localparam logic [3:0]   SATP_MODE_BARE = 4'd0;
  localparam logic [3:0]   SATP_MODE_SV39 = 4'd8;
  localparam logic [DELEG_W-1:0] DELEG_RESET = 16'hB3FF;

  function automatic xdata_t merge(input xdata_t old_v, input xdata_t new_v,
                                   input xdata_t mask);
    return (old_v & ~mask) | (new_v & mask);
  endfunction

  // supervisor views live in the machine entries
  function automatic csr_addr_t store_addr(input csr_addr_t a);
    csr_addr_t r;
    case (a)
      A_SSTATUS: r = A_MSTATUS;
      A_SIE:     r = A_MIE;
      A_SIP:     r = A_MIP;
      default:   r = a;
    endcase
    return r;
  endfunction

endpackage

// ----- src/riscv_csr_file.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_csr_file
// RV64 control and status register file held in one 4096 x 64 memory.
// ----------------------------------------------------------------------------
//  channel   ports                                         role
//  in        in_valid/in_stall, in_opcode, in_csr_address,
//            in_write_data                                 access beat
//  out       out_valid/out_stall, out_read_data            result beat
//  cfg       cfg_wr_en, cfg_wr_data                        medeleg writable mask
//
// An access reads its memory entry at the accept edge; the edge that ends
// the execute state merges, writes back and loads the output register.
// After reset a clearing pass writes every entry (misa and
// mstatus get their RV64 values); in_stall is high during it.
// A result held by out_stall keeps the following access in its execute state.
// ----------------------------------------------------------------------------
module riscv_csr_file (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [11:0]                 in_csr_address,
  input  logic [63:0]                 in_write_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [63:0]                 out_read_data,
  input  logic                        cfg_wr_en,
  input  logic [rcsr_pkg::DELEG_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                       state_r;
  rcsr_pkg::csr_addr_t          clr_cnt_r;
  logic                         out_valid_r;
  rcsr_pkg::xdata_t             out_data_r;
  logic [rcsr_pkg::DELEG_W-1:0] deleg_mask_r;

  logic                         op_r;
  rcsr_pkg::csr_addr_t          addr_r;
  rcsr_pkg::xdata_t             wdata_r;
  rcsr_pkg::xdata_t             rdata_r;

  rcsr_pkg::xdata_t             mem [rcsr_pkg::CSR_COUNT];

  logic                         in_accept;
  logic                         exec_done;
  logic                         wr_en;
  rcsr_pkg::xdata_t             wr_val;
  rcsr_pkg::xdata_t             rd_val;
  rcsr_pkg::xdata_t             clr_val;
  logic [3:0]                   satp_mode;

  assign in_stall      = (state_r != ST_IDLE);
  assign in_accept     = in_valid && !in_stall;
  assign exec_done     = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign satp_mode     = wdata_r[63:60];

  always_comb begin
    case (clr_cnt_r)
      rcsr_pkg::A_MISA:    clr_val = rcsr_pkg::MISA_RESET;
      rcsr_pkg::A_MSTATUS: clr_val = rcsr_pkg::MSTATUS_RESET;
      default:             clr_val = '0;
    endcase
  end

  // read view and write-back value from the fetched entry
  always_comb begin
    case (addr_r)
      rcsr_pkg::A_SSTATUS: rd_val = rdata_r & rcsr_pkg::SSTATUS_RD_MASK;
      rcsr_pkg::A_SIE,
      rcsr_pkg::A_SIP:     rd_val = rdata_r & rcsr_pkg::S_INT_MASK;
      rcsr_pkg::A_TSELECT,
      rcsr_pkg::A_TDATA1:  rd_val = '0;
      default:             rd_val = rdata_r;
    endcase
  end

  always_comb begin
    wr_en  = (op_r == rcsr_pkg::OP_WRITE);
    wr_val = wdata_r;
    case (addr_r)
      rcsr_pkg::A_SSTATUS:
        wr_val = rcsr_pkg::merge(rdata_r, wdata_r, rcsr_pkg::SSTATUS_WR_MASK);
      rcsr_pkg::A_MSTATUS:
        wr_val = rcsr_pkg::merge(rdata_r, wdata_r, rcsr_pkg::MSTATUS_WR_MASK);
      rcsr_pkg::A_MIE,
      rcsr_pkg::A_MIP:
        wr_val = wdata_r & rcsr_pkg::M_INT_MASK;
      rcsr_pkg::A_SIE,
      rcsr_pkg::A_SIP:
        wr_val = rcsr_pkg::merge(rdata_r, wdata_r, rcsr_pkg::S_INT_MASK);
      rcsr_pkg::A_MIDELEG:
        wr_val = wdata_r & rcsr_pkg::S_INT_MASK;
      rcsr_pkg::A_MEDELEG:
        wr_val = wdata_r & {{(rcsr_pkg::XLEN-rcsr_pkg::DELEG_W){1'b0}}, deleg_mask_r};
      rcsr_pkg::A_MISA,
      rcsr_pkg::A_TSELECT,
      rcsr_pkg::A_TDATA1,
      rcsr_pkg::A_MVENDORID,
      rcsr_pkg::A_MARCHID,
      rcsr_pkg::A_MIMPID:
        wr_en = 1'b0;
      rcsr_pkg::A_SATP: begin
        if (satp_mode != rcsr_pkg::SATP_MODE_BARE &&
            satp_mode != rcsr_pkg::SATP_MODE_SV39) begin
          wr_val = {rdata_r[63:60], wdata_r[59:0]};
        end
      end
      default: wr_val = wdata_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_done) begin
            out_valid_r <= 1'b1;
            out_data_r  <= (op_r == rcsr_pkg::OP_WRITE) ? '0 : rd_val;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deleg_mask_r <= rcsr_pkg::DELEG_RESET;
    end else if (cfg_wr_en) begin
      deleg_mask_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_opcode;
      addr_r  <= in_csr_address;
      wdata_r <= in_write_data;
    end
  end

  // one write port (clearing pass or write-back), one registered read port
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      mem[clr_cnt_r] <= clr_val;
    end else if (exec_done && wr_en) begin
      mem[rcsr_pkg::store_addr(addr_r)] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rdata_r <= mem[rcsr_pkg::store_addr(in_csr_address)];
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("input accepted during clearing pass");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_EXEC))
    else $error("accepted beat did not enter execute");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_done |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished access produced no result beat");

endmodule

// ----- tb/riscv_csr_file_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_csr_file_checker
// Watches the access, result and mask ports of the CSR file, keeps its own
// copy of the register store and the medeleg mask, works out the read data
// of every accepted access and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module riscv_csr_file_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [11:0]                  in_csr_address,
  input  logic [63:0]                  in_write_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [63:0]                  out_read_data,
  input  logic                         cfg_wr_en,
  input  logic [rcsr_pkg::DELEG_W-1:0] cfg_wr_data,
  output int                           errors,
  output int                           pending
);
  import rcsr_pkg::*;

  xdata_t               csr_mem [CSR_COUNT];
  logic [DELEG_W-1:0]   deleg_mask;
  xdata_t               read_q [$];
  int                   beats_checked;

  task automatic report_mismatch(input string msg);
    $display("%0t ns csr file mismatch: %s", $time, msg);
    errors++;
  endtask

  // applies one access to the local store and returns its read data
  function automatic xdata_t access_csr(input csr_op_t op, input csr_addr_t a,
                                        input xdata_t wd);
    xdata_t rd;
    rd = '0;
    if (op == OP_READ) begin
      case (a)
        A_SSTATUS:          rd = csr_mem[A_MSTATUS] & SSTATUS_RD_MASK;
        A_SIE:              rd = csr_mem[A_MIE] & S_INT_MASK;
        A_SIP:              rd = csr_mem[A_MIP] & S_INT_MASK;
        A_TSELECT, A_TDATA1: rd = '0;
        default:            rd = csr_mem[a];
      endcase
    end else begin
      case (a)
        A_SSTATUS: csr_mem[A_MSTATUS] = (csr_mem[A_MSTATUS] & ~SSTATUS_WR_MASK) |
                                        (wd & SSTATUS_WR_MASK);
        A_MSTATUS: csr_mem[A_MSTATUS] = (csr_mem[A_MSTATUS] & ~MSTATUS_WR_MASK) |
                                        (wd & MSTATUS_WR_MASK);
        A_MIE, A_MIP: csr_mem[a] = wd & M_INT_MASK;
        A_SIE: csr_mem[A_MIE] = (csr_mem[A_MIE] & ~S_INT_MASK) | (wd & S_INT_MASK);
        A_SIP: csr_mem[A_MIP] = (csr_mem[A_MIP] & ~S_INT_MASK) | (wd & S_INT_MASK);
        A_MIDELEG: csr_mem[A_MIDELEG] = wd & S_INT_MASK;
        A_MEDELEG: csr_mem[A_MEDELEG] = wd & {{(XLEN-DELEG_W){1'b0}}, deleg_mask};
        A_MISA, A_TSELECT, A_TDATA1, A_MVENDORID, A_MARCHID, A_MIMPID: begin
        end
        A_SATP: begin
          // unsupported translation modes leave the old mode in place
          if (wd[63:60] != SATP_MODE_BARE && wd[63:60] != SATP_MODE_SV39)
            csr_mem[A_SATP] = {csr_mem[A_SATP][63:60], wd[59:0]};
          else
            csr_mem[A_SATP] = wd;
        end
        default: csr_mem[a] = wd;
      endcase
    end
    return rd;
  endfunction

  always @(posedge clk) begin
    xdata_t want;
    if (!rst_n) begin
      for (int i = 0; i < CSR_COUNT; i++)
        csr_mem[i] = '0;
      csr_mem[A_MISA]    = MISA_RESET;
      csr_mem[A_MSTATUS] = MSTATUS_RESET;
      deleg_mask         = DELEG_RESET;
      read_q.delete();
      errors             = 0;
      beats_checked      = 0;
    end else begin
      if (cfg_wr_en)
        deleg_mask = cfg_wr_data;
      // push before popping so a same-edge access never shadows the oldest one
      if (in_valid && !in_stall)
        read_q.push_back(access_csr(csr_op_t'(in_opcode), in_csr_address,
                                    in_write_data));
      if (out_valid && !out_stall) begin
        if (read_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with no access outstanding",
                                    out_read_data));
        end else begin
          want = read_q.pop_front();
          if (out_read_data !== want)
            report_mismatch($sformatf("beat %0d read_data %h, want %h",
                                      beats_checked, out_read_data, want));
        end
        beats_checked++;
      end
    end
    pending = read_q.size();
  end

endmodule

// ----- tb/riscv_csr_file_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_csr_file_tb
// Drives directed and random CSR accesses into the RV64 CSR file under
// random source gaps and sink stalls, changes the medeleg mask between
// phases, and takes the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module riscv_csr_file_tb;
  import rcsr_pkg::*;

  localparam int        CYCLE_LIMIT  = 1000000;
  localparam int        PHASES       = 5;
  localparam int        PHASE_ITEMS  = 360;
  localparam int        PRESSURE_AT  = 600;
  localparam int        HOLD_CYCLES  = 400;
  localparam csr_addr_t A_LOWEST     = 12'h000;
  localparam csr_addr_t A_HIGHEST    = 12'hFFF;
  localparam csr_addr_t A_SSCRATCH   = 12'h140;
  localparam csr_addr_t A_MSCRATCH   = 12'h340;
  localparam csr_addr_t A_MEPC       = 12'h341;
  localparam csr_addr_t A_MHARTID    = 12'hF14;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_opcode;
  logic [11:0]        in_csr_address;
  logic [63:0]        in_write_data;
  logic               out_valid;
  logic               out_stall;
  logic [63:0]        out_read_data;
  logic               cfg_wr_en;
  logic [DELEG_W-1:0] cfg_wr_data;

  int errors;
  int pending;
  int accesses_sent;
  int send_mode;
  int send_left;
  int cycle_count = 0;

  riscv_csr_file u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_csr_address (in_csr_address),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  riscv_csr_file_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_csr_address (in_csr_address),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .errors         (errors),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("riscv_csr_file_tb NOT OK");
      $finish;
    end
  end

  // mode 0 never idles, mode 1 idles now and then, mode 2 idles often
  function automatic int idle_len(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || (mode == 1 && r >= 15) || (mode >= 2 && r >= 50))
      return 0;
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(15, 50);
    return $urandom_range(1, 3);
  endfunction

  function automatic csr_addr_t pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      case ($urandom_range(0, 14))
        0:       return A_SSTATUS;
        1:       return A_SIE;
        2:       return A_SIP;
        3:       return A_SATP;
        4:       return A_MSTATUS;
        5:       return A_MISA;
        6:       return A_MEDELEG;
        7:       return A_MIDELEG;
        8:       return A_MIE;
        9:       return A_MIP;
        10:      return A_TSELECT;
        11:      return A_TDATA1;
        12:      return A_MVENDORID;
        13:      return A_MARCHID;
        default: return A_MIMPID;
      endcase
    end
    if (r < 75) begin
      case ($urandom_range(0, 5))
        0:       return A_LOWEST;
        1:       return A_HIGHEST;
        2:       return A_SSCRATCH;
        3:       return A_MSCRATCH;
        4:       return A_MEPC;
        default: return A_MHARTID;
      endcase
    end
    return csr_addr_t'($urandom_range(0, CSR_COUNT - 1));
  endfunction

  function automatic xdata_t pick_data(input csr_addr_t a);
    xdata_t d;
    case ($urandom_range(0, 7))
      0:       d = '0;
      1:       d = '1;
      2:       d = xdata_t'(1) << $urandom_range(0, XLEN - 1);
      default: d = {$urandom, $urandom};
    endcase
    if (a == A_SATP) begin
      case ($urandom_range(0, 2))
        0:       d[63:60] = SATP_MODE_BARE;
        1:       d[63:60] = SATP_MODE_SV39;
        default: d[63:60] = d[63:60];
      endcase
    end
    return d;
  endfunction

  // drops valid when n is positive and scrambles the idle payload
  task automatic idle_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid       <= 1'b0;
      in_opcode      <= 1'($urandom_range(0, 1));
      in_csr_address <= csr_addr_t'($urandom_range(0, CSR_COUNT - 1));
      in_write_data  <= {$urandom, $urandom};
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_access(input csr_op_t op, input csr_addr_t a, input xdata_t d);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_csr_address <= a;
    in_write_data  <= d;
    forever begin
      @(posedge clk);
      if (!in_stall)
        break;
    end
    accesses_sent++;
    if (send_left == 0) begin
      send_mode = $urandom_range(0, 2);
      send_left = $urandom_range(40, 160);
    end
    send_left--;
    idle_input(idle_len(send_mode));
  endtask

  // mostly write-then-read pairs, some through the supervisor alias
  task automatic random_sequence();
    csr_addr_t a;
    csr_addr_t b;
    xdata_t    d;
    int        kind;
    a    = pick_addr();
    d    = pick_data(a);
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      send_access(OP_WRITE, a, d);
      send_access(OP_READ, a, {$urandom, $urandom});
    end else if (kind < 7) begin
      case (a)
        A_SSTATUS: b = A_MSTATUS;
        A_MSTATUS: b = A_SSTATUS;
        A_SIE:     b = A_MIE;
        A_MIE:     b = A_SIE;
        A_SIP:     b = A_MIP;
        A_MIP:     b = A_SIP;
        default:   b = a;
      endcase
      send_access(OP_WRITE, a, d);
      send_access(OP_READ, b, {$urandom, $urandom});
    end else begin
      send_access(csr_op_t'($urandom_range(0, 1)), a, d);
    end
  endtask

  // result side: random stalls plus one long hold-off to back up the block
  initial begin : result_sink
    int  stretch_left;
    int  rx_mode;
    int  stall_left;
    int  hold_left;
    bit  pressure_done;
    bit  stall_now;
    out_stall     = 1'b0;
    stretch_left  = 0;
    rx_mode       = 0;
    stall_left    = 0;
    hold_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (stretch_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        stretch_left = $urandom_range(40, 200);
      end
      stretch_left--;
      if (!pressure_done && accesses_sent >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else begin
        if (stall_left > 0)
          stall_left--;
        else
          stall_left = idle_len(rx_mode);
        stall_now = (stall_left > 0);
      end
      out_stall <= stall_now;
    end
  end

  initial begin : access_source
    logic [DELEG_W-1:0] mask;
    int                 target;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_READ;
    in_csr_address = '0;
    in_write_data  = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    accesses_sent  = 0;
    send_mode      = 0;
    send_left      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values, alias views and field masks
    send_access(OP_READ,  A_MISA,    '1);
    send_access(OP_READ,  A_MSTATUS, '0);
    send_access(OP_READ,  A_SSTATUS, '0);
    send_access(OP_WRITE, A_MSTATUS, '1);
    send_access(OP_READ,  A_MSTATUS, '0);
    send_access(OP_READ,  A_SSTATUS, '0);
    send_access(OP_WRITE, A_SSTATUS, '0);
    send_access(OP_READ,  A_MSTATUS, '0);
    send_access(OP_WRITE, A_MIE,     '1);
    send_access(OP_READ,  A_SIE,     '0);
    send_access(OP_WRITE, A_SIP,     '1);
    send_access(OP_READ,  A_MIP,     '0);
    send_access(OP_WRITE, A_MIDELEG, '1);
    send_access(OP_READ,  A_MIDELEG, '0);
    send_access(OP_WRITE, A_MEDELEG, '1);
    send_access(OP_READ,  A_MEDELEG, '0);
    // read-only and hardwired-zero registers
    send_access(OP_WRITE, A_MISA,    '0);
    send_access(OP_READ,  A_MISA,    '0);
    send_access(OP_WRITE, A_TDATA1,  '1);
    send_access(OP_READ,  A_TDATA1,  '1);
    // satp keeps its mode on an unsupported one
    send_access(OP_WRITE, A_SATP,    {SATP_MODE_SV39, 60'h0AB_CDEF_0123_4567});
    send_access(OP_WRITE, A_SATP,    '1);
    send_access(OP_READ,  A_SATP,    '0);
    send_access(OP_WRITE, A_HIGHEST, '1);
    send_access(OP_READ,  A_HIGHEST, '0);
    send_access(OP_READ,  A_LOWEST,  '1);

    for (int p = 0; p < PHASES; p++) begin
      idle_input(1);
      wait (pending == 0);
      case (p)
        0:       mask = '1;
        1:       mask = '0;
        3:       mask = DELEG_RESET;
        default: mask = DELEG_W'($urandom_range(0, (1 << DELEG_W) - 1));
      endcase
      @(negedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= mask;
      @(negedge clk);
      cfg_wr_en   <= 1'b0;
      target = accesses_sent + PHASE_ITEMS;
      while (accesses_sent < target)
        random_sequence();
    end

    idle_input(1);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("riscv_csr_file_tb OK");
    else
      $display("riscv_csr_file_tb NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
src/rcsr_pkg.sv
src/riscv_csr_file.sv
tb/riscv_csr_file_checker.sv
tb/riscv_csr_file_tb.sv
